FILE: src/mt_pkg.sv
// ----------------------------------------------------------------------------
// mt_pkg
// Types, constants and the tempering function of the 32-bit Mersenne
// Twister generator.
// ----------------------------------------------------------------------------
package mt_pkg;

   // state vector geometry
   localparam int STATE_WORDS  = 624;
   localparam int TWIST_OFFSET = 397;
   localparam int WORD_W       = 32;
   localparam int IDX_W        = $clog2(STATE_WORDS);

   typedef logic [WORD_W-1:0] word_type;
   typedef logic [IDX_W-1:0]  idx_type;

   localparam idx_type  LAST_IDX   = idx_type'(STATE_WORDS - 1);

   // seeding and twist constants
   localparam word_type SEED_RESET = 32'd4357;
   localparam word_type SEED_MULT  = 32'd69069;
   localparam word_type TWIST_XOR  = 32'h9908_b0df;
   localparam word_type TEMPER_B   = 32'h9d2c_5680;
   localparam word_type TEMPER_C   = 32'hefc6_0000;

   // output tempering
   function automatic word_type temper(input word_type y_in);
      word_type y;
      y = y_in;
      y = y ^ (y >> 11);
      y = y ^ ((y << 7) & TEMPER_B);
      y = y ^ ((y << 15) & TEMPER_C);
      y = y ^ (y >> 18);
      return y;
   endfunction

endpackage

FILE: src/mersenne_twister_generator.sv
// ----------------------------------------------------------------------------
// mersenne_twister_generator
// 32-bit MT19937 generator with multiplier-69069 seeding; the twist is done
// one word per draw request, so each draw request returns one tempered word.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  req     | in        | req_valid/req_stall | req_draw (1 bit)
//  rsp     | out       | rsp_valid/rsp_stall | rsp_random_word (32 bits)
//  csr     | in        | csr_wr_en           | csr_wr_data (seed, 32 bits)
//
//  One request per cycle while req_stall is low; a word passes the read
//  stage of the two state RAMs, then the output register.
//  After reset and after every seed write the 624-word state is refilled,
//  one word per cycle through the 69069 multiplier, with req_stall high.
//  A stalled response holds the output register and the twist stage, and
//  outside the fill req_stall rises only when both are full.
// ----------------------------------------------------------------------------
module mersenne_twister_generator (
   input  logic                 clock,
   input  logic                 reset,
   // request channel
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_draw,
   // response channel
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output mt_pkg::word_type     rsp_random_word,
   // seed register
   input  logic                 csr_wr_en,
   input  mt_pkg::word_type     csr_wr_data
);

   // next index around the ring
   function automatic mt_pkg::idx_type idx_next(input mt_pkg::idx_type i);
      return (i == mt_pkg::LAST_IDX) ? '0 : mt_pkg::idx_type'(i + 1'b1);
   endfunction

   // index of the word TWIST_OFFSET ahead, around the ring
   function automatic mt_pkg::idx_type idx_far(input mt_pkg::idx_type i);
      logic [mt_pkg::IDX_W:0] sum;
      sum = {1'b0, i} + (mt_pkg::IDX_W+1)'(mt_pkg::TWIST_OFFSET);
      if (sum >= (mt_pkg::IDX_W+1)'(mt_pkg::STATE_WORDS)) begin
         sum = sum - (mt_pkg::IDX_W+1)'(mt_pkg::STATE_WORDS);
      end
      return sum[mt_pkg::IDX_W-1:0];
   endfunction

   logic             fill_ff, fill_in;
   mt_pkg::idx_type  fill_addr_ff, fill_addr_in;
   mt_pkg::word_type fill_word_ff, fill_word_in;
   mt_pkg::idx_type  idx_ff, idx_in;
   mt_pkg::word_type cur_ff, cur_in;
   logic             s1_valid_ff, s1_valid_in;
   mt_pkg::idx_type  s1_idx_ff, s1_idx_in;
   logic             out_valid_ff, out_valid_in;
   mt_pkg::word_type out_word_ff, out_word_in;

   logic             accept, draw_go, adv1;
   mt_pkg::word_type next_rd, far_rd, mix, twisted;
   logic             wr_en;
   mt_pkg::idx_type  wr_addr;
   mt_pkg::word_type wr_data;

   // handshake control
   always_comb begin
      adv1      = s1_valid_ff & (~out_valid_ff | ~rsp_stall);
      req_stall = fill_ff | (s1_valid_ff & ~adv1);
      accept    = req_valid & ~req_stall;
      draw_go   = accept & req_draw;
   end

   // twist of the current word from its neighbor and the far word
   always_comb begin
      mix     = {cur_ff[31], next_rd[30:0]};
      twisted = far_rd ^ (mix >> 1) ^ (mix[0] ? mt_pkg::TWIST_XOR : '0);
   end

   // shared write port: fill sweep or twist write-back
   always_comb begin
      wr_en   = fill_ff | adv1;
      wr_addr = fill_ff ? fill_addr_ff : s1_idx_ff;
      wr_data = fill_ff ? fill_word_ff : twisted;
   end

   // two copies of the state, one read port each
   mt_ram #(
      .WIDTH (mt_pkg::WORD_W),
      .DEPTH (mt_pkg::STATE_WORDS)
   ) u_ram_next (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (draw_go),
      .rd_addr (idx_next(idx_ff)),
      .rd_data (next_rd)
   );

   mt_ram #(
      .WIDTH (mt_pkg::WORD_W),
      .DEPTH (mt_pkg::STATE_WORDS)
   ) u_ram_far (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (draw_go),
      .rd_addr (idx_far(idx_ff)),
      .rd_data (far_rd)
   );

   // next-state logic
   always_comb begin
      fill_in      = fill_ff;
      fill_addr_in = fill_addr_ff;
      fill_word_in = fill_word_ff;
      idx_in       = idx_ff;
      cur_in       = cur_ff;
      s1_valid_in  = draw_go | (s1_valid_ff & ~adv1);
      s1_idx_in    = draw_go ? idx_ff : s1_idx_ff;
      out_valid_in = adv1 | (out_valid_ff & rsp_stall);
      out_word_in  = adv1 ? mt_pkg::temper(twisted) : out_word_ff;

      // fill sweep, one word per cycle
      if (fill_ff) begin
         fill_addr_in = mt_pkg::idx_type'(fill_addr_ff + 1'b1);
         fill_word_in = fill_word_ff * mt_pkg::SEED_MULT;
         if (fill_addr_ff == mt_pkg::LAST_IDX) begin
            fill_in = 1'b0;
         end
      end

      // request index and current word
      if (draw_go) begin
         idx_in = idx_next(idx_ff);
      end
      if (adv1) begin
         cur_in = next_rd;
      end

      // seed write restarts the fill
      if (csr_wr_en) begin
         fill_in      = 1'b1;
         fill_addr_in = '0;
         fill_word_in = csr_wr_data;
         idx_in       = '0;
         cur_in       = csr_wr_data;
      end
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= 1'b1;
         fill_addr_ff <= '0;
         fill_word_ff <= mt_pkg::SEED_RESET;
         idx_ff       <= '0;
         cur_ff       <= mt_pkg::SEED_RESET;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         fill_addr_ff <= fill_addr_in;
         fill_word_ff <= fill_word_in;
         idx_ff       <= idx_in;
         cur_ff       <= cur_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      s1_idx_ff   <= s1_idx_in;
      out_word_ff <= out_word_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_random_word = out_word_ff;

endmodule

FILE: src/mt_ram.sv
// ----------------------------------------------------------------------------
// mt_ram
// Generic single-write, single-read synchronous RAM with registered read
// data; the read register only loads when a read is enabled.
// ----------------------------------------------------------------------------
module mt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 624
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/mt_checker.sv
// ----------------------------------------------------------------------------
// mt_checker
// Port-level checks of the Mersenne Twister generator, bound to the top
// level.
// ----------------------------------------------------------------------------
module mt_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             req_draw,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input mt_pkg::word_type rsp_random_word,
   input logic             csr_wr_en
);

   // an accepted request with draw set shows a word after the RAM read and output registers
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_draw) |-> ##2 rsp_valid)
      else $error("no response two cycles after a draw request");

   // reset starts the state fill
   assert property (@(posedge clock)
      reset |=> req_stall)
      else $error("requests taken right after reset");

   // a seed write starts the state fill
   assert property (@(posedge clock) disable iff (reset)
      csr_wr_en |=> req_stall)
      else $error("requests taken right after a seed write");

   // stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_random_word)))
      else $error("stalled response changed");

endmodule

bind mersenne_twister_generator mt_checker u_mt_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .req_draw        (req_draw),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_random_word (rsp_random_word),
   .csr_wr_en       (csr_wr_en)
);
